// ===== design/cssh_pkg.sv =====
// Shared types and constants for the control surface SysEx handshake block.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package cssh_pkg;

   // Register map
   localparam int unsigned CSR_ADDR_W      = 2;
   localparam int unsigned CSR_DATA_W      = 32;
   localparam logic [1:0]  CSR_DEVICE_ID   = 2'd0;
   localparam logic [6:0]  DEVICE_ID_RESET = 7'd20;

   // Job queue between front and back
   localparam int unsigned JOB_DEPTH = 2;

   // Job codes
   localparam logic [1:0] JOB_QUERY   = 2'd0;
   localparam logic [1:0] JOB_REPLY   = 2'd1;
   localparam logic [1:0] JOB_CONFIRM = 2'd2;

   // Link states carried on results
   localparam logic [1:0] LINK_IDLE      = 2'd0;
   localparam logic [1:0] LINK_WAIT_CHAL = 2'd1;
   localparam logic [1:0] LINK_WAIT_CONF = 2'd2;
   localparam logic [1:0] LINK_CONNECTED = 2'd3;

   // Input kinds
   localparam logic KIND_RX_BYTE = 1'b0;
   localparam logic KIND_START   = 1'b1;

   // Message bytes
   localparam logic [7:0] SYX_START   = 8'hF0;
   localparam logic [7:0] SYX_END     = 8'hF7;
   localparam logic [7:0] HDR_ZERO    = 8'h00;
   localparam logic [7:0] HDR_MAKER   = 8'h66;
   localparam logic [7:0] CMD_QUERY   = 8'h00;
   localparam logic [7:0] CMD_CHAL    = 8'h01;
   localparam logic [7:0] CMD_REPLY   = 8'h02;
   localparam logic [7:0] CMD_CONFIRM = 8'h03;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       event_res;
      logic [1:0] link_state;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      code;
      logic [6:0]      dev_id;
      logic [6:0][7:0] serial;
      logic [3:0][7:0] chal;
   } job_type;

endpackage

`default_nettype wire

// ===== design/cssh_front.sv =====
// Front end: tracks the received message, classifies finished messages
// and start commands into jobs. Depends on cssh_pkg.
`default_nettype none

module cssh_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire cssh_pkg::req_type req,
   input  wire logic [6:0]        device_id,
   output logic                   job_push,
   output cssh_pkg::job_type      job
);

   logic [4:0]      pos_ff,   pos_in;
   logic            hdr_ff,   hdr_in;
   logic [7:0]      dev_ff,   dev_in;
   logic [7:0]      cmd_ff,   cmd_in;
   logic [7:0]      serial_ff [7];
   logic [7:0]      chal_ff   [4];
   logic            rx_accept;
   logic            msg_ok;
   logic [2:0]      serial_idx;
   logic [1:0]      chal_idx;

   assign rx_accept  = accept && (req.kind == cssh_pkg::KIND_RX_BYTE);
   assign serial_idx = 3'(pos_ff - 5'd6);
   assign chal_idx   = 2'(pos_ff - 5'd13);

   // Header and id are final once the position is past byte 5.
   assign msg_ok = (pos_ff >= 5'd6) && hdr_ff && (dev_ff == {1'b0, device_id});

   always_comb begin
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      dev_in = dev_ff;
      cmd_in = cmd_ff;
      if (rx_accept) begin
         if (((pos_ff == 5'd1) && (req.rx_byte != cssh_pkg::HDR_ZERO)) ||
             ((pos_ff == 5'd2) && (req.rx_byte != cssh_pkg::HDR_ZERO)) ||
             ((pos_ff == 5'd3) && (req.rx_byte != cssh_pkg::HDR_MAKER))) begin
            hdr_in = 1'b0;
         end
         if (pos_ff == 5'd4) begin
            dev_in = req.rx_byte;
         end
         if (pos_ff == 5'd5) begin
            cmd_in = req.rx_byte;
         end
         if (req.rx_last) begin
            pos_in = '0;
            hdr_in = 1'b1;
         end else if (pos_ff != 5'd31) begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hdr_ff <= 1'b1;
         dev_ff <= '0;
         cmd_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hdr_ff <= hdr_in;
         dev_ff <= dev_in;
         cmd_ff <= cmd_in;
      end
   end

   // Serial and challenge bytes, no reset.
   always_ff @(posedge clock) begin
      if (rx_accept && (pos_ff >= 5'd6) && (pos_ff <= 5'd12)) begin
         serial_ff[serial_idx] <= req.rx_byte;
      end
      if (rx_accept && (pos_ff >= 5'd13) && (pos_ff <= 5'd16)) begin
         chal_ff[chal_idx] <= req.rx_byte;
      end
   end

   always_comb begin
      job_push   = 1'b0;
      job.code   = cssh_pkg::JOB_QUERY;
      job.dev_id = device_id;
      for (int i = 0; i < 7; i++) begin
         job.serial[i] = serial_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         job.chal[i] = chal_ff[i];
      end
      if (accept) begin
         priority if (req.kind == cssh_pkg::KIND_START) begin
            job_push = 1'b1;
            job.code = cssh_pkg::JOB_QUERY;
         end else if (req.rx_last && msg_ok && (cmd_ff == cssh_pkg::CMD_CHAL) &&
                      (pos_ff >= 5'd17)) begin
            job_push = 1'b1;
            job.code = cssh_pkg::JOB_REPLY;
         end else if (req.rx_last && msg_ok && (cmd_ff == cssh_pkg::CMD_CONFIRM)) begin
            job_push = 1'b1;
            job.code = cssh_pkg::JOB_CONFIRM;
         end else begin
            job_push = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/cssh_job_fifo.sv =====
// Short job queue between the front and back ends.
// Depends on cssh_pkg for the job type.
`default_nettype none

module cssh_job_fifo #(
   parameter int unsigned DEPTH = cssh_pkg::JOB_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cssh_pkg::job_type wr_data,
   input  wire logic              pop,
   output cssh_pkg::job_type      rd_data,
   output logic                   full,
   output logic                   empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cssh_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/cssh_back.sv =====
// Back end: plays a job out as result transfers through an output register.
// Depends on cssh_pkg for the job and result types.
`default_nettype none

module cssh_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cssh_pkg::job_type job_data,
   input  wire logic              job_empty,
   output logic                   job_pop,
   output logic                   out_valid,
   output cssh_pkg::rsp_type      out_data,
   input  wire logic              out_pop
);

   cssh_pkg::job_type job_ff;
   logic [4:0]        idx_ff, idx_in;
   logic              busy_ff, busy_in;
   logic              valid_ff, valid_in;
   cssh_pkg::rsp_type data_ff, data_in;
   cssh_pkg::rsp_type cur;
   logic              can_load;
   logic [7:0]        resp [4];

   // Reply bytes from the stored challenge; only the low 7 bits are kept.
   always_comb begin
      logic [7:0] c0, c1, c2, c3;
      c0 = job_ff.chal[0];
      c1 = job_ff.chal[1];
      c2 = job_ff.chal[2];
      c3 = job_ff.chal[3];
      resp[0] = 8'h7F & (c0 + (c1 ^ 8'h0A) - c3);
      resp[1] = 8'h7F & ((c2 >> 4) ^ (c0 + c3));
      resp[2] = 8'h7F & ((c3 - (c2 << 2)) ^ (c0 | c1));
      resp[3] = 8'h7F & (c1 - c2 + (8'hF0 ^ (c3 << 4)));
   end

   always_comb begin
      cur.tx_byte    = cssh_pkg::HDR_ZERO;
      cur.tx_last    = 1'b1;
      cur.event_res  = 1'b0;
      cur.link_state = cssh_pkg::LINK_IDLE;
      unique case (job_ff.code)
         cssh_pkg::JOB_QUERY: begin
            cur.tx_last    = (idx_ff == 5'd6);
            cur.link_state = cssh_pkg::LINK_WAIT_CHAL;
            unique case (idx_ff)
               5'd0:    cur.tx_byte = cssh_pkg::SYX_START;
               5'd1:    cur.tx_byte = cssh_pkg::HDR_ZERO;
               5'd2:    cur.tx_byte = cssh_pkg::HDR_ZERO;
               5'd3:    cur.tx_byte = cssh_pkg::HDR_MAKER;
               5'd4:    cur.tx_byte = {1'b0, job_ff.dev_id};
               5'd5:    cur.tx_byte = cssh_pkg::CMD_QUERY;
               default: cur.tx_byte = cssh_pkg::SYX_END;
            endcase
         end
         cssh_pkg::JOB_REPLY: begin
            cur.tx_last    = (idx_ff == 5'd17);
            cur.link_state = cssh_pkg::LINK_WAIT_CONF;
            unique case (idx_ff)
               5'd0:    cur.tx_byte = cssh_pkg::SYX_START;
               5'd1:    cur.tx_byte = cssh_pkg::HDR_ZERO;
               5'd2:    cur.tx_byte = cssh_pkg::HDR_ZERO;
               5'd3:    cur.tx_byte = cssh_pkg::HDR_MAKER;
               5'd4:    cur.tx_byte = {1'b0, job_ff.dev_id};
               5'd5:    cur.tx_byte = cssh_pkg::CMD_REPLY;
               5'd6:    cur.tx_byte = job_ff.serial[0];
               5'd7:    cur.tx_byte = job_ff.serial[1];
               5'd8:    cur.tx_byte = job_ff.serial[2];
               5'd9:    cur.tx_byte = job_ff.serial[3];
               5'd10:   cur.tx_byte = job_ff.serial[4];
               5'd11:   cur.tx_byte = job_ff.serial[5];
               5'd12:   cur.tx_byte = job_ff.serial[6];
               5'd13:   cur.tx_byte = resp[0];
               5'd14:   cur.tx_byte = resp[1];
               5'd15:   cur.tx_byte = resp[2];
               5'd16:   cur.tx_byte = resp[3];
               default: cur.tx_byte = cssh_pkg::SYX_END;
            endcase
         end
         cssh_pkg::JOB_CONFIRM: begin
            cur.event_res  = 1'b1;
            cur.link_state = cssh_pkg::LINK_CONNECTED;
         end
         default: begin
            cur.tx_last = 1'b1;
         end
      endcase
   end

   assign can_load  = !valid_ff || out_pop;
   assign job_pop   = !busy_ff && !job_empty;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff && !out_pop;
      data_in  = data_ff;
      if (job_pop) begin
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && can_load) begin
         valid_in = 1'b1;
         data_in  = cur;
         idx_in   = idx_ff + 5'd1;
         busy_in  = !cur.tx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (job_pop) begin
         job_ff <= job_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/control_surface_sysex_handshake_top.sv =====
// Top level of the control surface SysEx handshake block.
// Depends on cssh_pkg, cssh_front, cssh_job_fifo and cssh_back.
//
// Use:
//   Input channel (req_): push one item per transfer while req_full is low.
//   An item is either one received SysEx byte (kind 0, rx_last on the final
//   byte) or a start command (kind 1).
//   A start command queues the 7-byte device query; a valid challenge
//   queues the 18-byte reply; a valid confirm queues one completion notice.
//   Result channel (rsp_): the oldest result sits on rsp_payload while
//   rsp_empty is low and leaves on a transfer with rsp_pop high.
//   A run's first result passes through the job queue, the back end's job
//   register and the output register; the run then streams one result per
//   cycle while rsp_pop is high; between runs the next job is loaded.
//   The job queue holds JOB_DEPTH runs; when it is full, req_full rises and
//   input stalls until the back end takes a job. A stalled receiver holds
//   the output register and, behind it, the queue, without losing data.
//   CSR port: device_id at byte address 0 (reset 20), written on the APB
//   access cycle; pready is always high. Write it only while idle.
//   Reset (synchronous) clears the reception state, the queue and the
//   output register; the serial and challenge stores are not cleared.
`default_nettype none

module control_surface_sysex_handshake_top #(
   parameter int unsigned JOB_DEPTH = cssh_pkg::JOB_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire cssh_pkg::req_type                 req_payload,
   // result channel
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output cssh_pkg::rsp_type                      rsp_payload,
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cssh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cssh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cssh_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   logic              dev_id_we;
   logic [6:0]        dev_id_ff, dev_id_in;
   logic              req_accept;
   logic              job_push;
   cssh_pkg::job_type job_wr;
   cssh_pkg::job_type job_rd;
   logic              job_pop;
   logic              job_full;
   logic              job_empty;
   logic              out_valid;

   // Config register
   assign csr_pready = 1'b1;
   assign dev_id_we  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == cssh_pkg::CSR_DEVICE_ID);
   assign dev_id_in  = dev_id_we ? csr_pwdata[6:0] : dev_id_ff;
   assign csr_prdata = (csr_paddr == cssh_pkg::CSR_DEVICE_ID) ?
                       {{(cssh_pkg::CSR_DATA_W-7){1'b0}}, dev_id_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_id_ff <= cssh_pkg::DEVICE_ID_RESET;
      end else begin
         dev_id_ff <= dev_id_in;
      end
   end

   // Stall input whenever the queue cannot take a job, so a last byte
   // never finds it full.
   assign req_full   = job_full;
   assign req_accept = req_push && !req_full;

   cssh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_payload),
      .device_id (dev_id_ff),
      .job_push  (job_push),
      .job       (job_wr)
   );

   cssh_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .pop     (job_pop),
      .rd_data (job_rd),
      .full    (job_full),
      .empty   (job_empty)
   );

   cssh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_rd),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .out_valid (out_valid),
      .out_data  (rsp_payload),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty = !out_valid;

   // A completion notice is always a single, final result in the connected state.
   a_notice_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.event_res) |->
      (rsp_payload.tx_last && (rsp_payload.link_state == cssh_pkg::LINK_CONNECTED)))
      else $error("completion notice malformed");

   // The front never pushes a job into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job pushed into full queue");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");

   // A transmitted byte is never tagged with the idle link state.
   a_tx_state: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_payload.event_res) |->
      (rsp_payload.link_state != cssh_pkg::LINK_IDLE))
      else $error("transmit byte in idle state");

endmodule

`default_nettype wire
